[sv/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared constants, codes and controller/datapath interface types for the
// converter scan sequencer.
// ----------------------------------------------------------------------------
package acs_pkg;

  // Default configuration of the sequencer.
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int NUM_PORTS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF  = 12;

  // Field widths fixed by the interface.
  localparam int KIND_W    = 3;
  localparam int WORD_W    = 16;
  localparam int CHAN_W    = 4;
  localparam int PORT_W    = 2;
  localparam int PHASE_W   = 2;
  localparam int PERIOD_W  = 2;
  localparam int VALUE_W   = 13;
  localparam int COUNT_W   = 8;
  localparam int MASK_W    = 4;
  localparam int MAP_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MV     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COLOR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECTED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MSK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAP  = 2'd2;

  // Poll period codes.
  localparam logic [PERIOD_W-1:0] PERIOD_SLOW  = 2'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_FAST  = 2'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_COLOR = 2'd2;

  // Converter commands.
  localparam logic [WORD_W-1:0] CMD_MANUAL_BASE = 16'h1840;
  localparam logic [WORD_W-1:0] CMD_AUTO        = 16'h2840;
  localparam int                CMD_CH_SHIFT    = 7;

  // Color phases per port.
  localparam int                 PHASES     = 4;
  localparam logic [PHASE_W-1:0] LAST_PHASE = 2'd3;

  // Millivolt conversion: raw * LSB_UV / 1000, done as a multiply by a
  // rounded-up reciprocal and a right shift. With a 22-bit shift the error
  // stays below one thousandth for every raw sample, so the floor is exact.
  localparam int REF_UV   = 2500000;
  localparam int MV_DIV   = 1000;
  localparam int MV_SHIFT = 22;
  localparam int MV_MUL_W = 28;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic commit_step;
  } acs_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic res_now;
    logic commit_start;
    logic commit_last;
  } acs_sts_t;

endpackage

[sv/acs_ctrl.sv]
// ----------------------------------------------------------------------------
// acs_ctrl
// Controller: input and output handshakes and commit sequencing.
// ----------------------------------------------------------------------------
module acs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  acs_pkg::acs_sts_t sts_i,
  output acs_pkg::acs_cmd_t cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_COMMIT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_set;

  // Items are taken only when idle and the result register is free or draining.
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.accept      = accept;
  assign cmd_o.commit_step = (state_q == ST_COMMIT);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.commit_start) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.commit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The result register fills when an item with a result is taken.
  assign out_set     = accept && sts_i.res_now;
  assign out_valid_d = out_set || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/acs_dpath.sv]
// ----------------------------------------------------------------------------
// acs_dpath
// Datapath: configuration, sequencing state, sample and color stores, frame
// staging, millivolt scaling by constant multiply, result register.
// ----------------------------------------------------------------------------
module acs_dpath #(
  parameter int NUM_CHANNELS = acs_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_PORTS    = acs_pkg::NUM_PORTS_DEF,
  parameter int SAMPLE_BITS  = acs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [acs_pkg::MAP_W-1:0]       cfg_wdata_i,
  input  logic [acs_pkg::KIND_W-1:0]      kind_i,
  input  logic [acs_pkg::WORD_W-1:0]      rx_word_i,
  input  logic                            transfer_error_i,
  input  logic [acs_pkg::CHAN_W-1:0]      channel_i,
  input  logic [acs_pkg::PORT_W-1:0]      port_i,
  input  logic [acs_pkg::PHASE_W-1:0]     color_index_i,
  input  acs_pkg::acs_cmd_t               cmd_i,
  output acs_pkg::acs_sts_t               sts_o,
  output logic                            issued_o,
  output logic [acs_pkg::WORD_W-1:0]      command_word_o,
  output logic                            scan_frame_o,
  output logic [acs_pkg::PERIOD_W-1:0]    period_select_o,
  output logic [acs_pkg::VALUE_W-1:0]     read_value_o,
  output logic                            stopped_o
);

  localparam int     CH_W      = $clog2(NUM_CHANNELS);
  localparam int     POS_W     = $clog2(NUM_CHANNELS + 1);
  localparam int     CDEPTH    = NUM_PORTS * acs_pkg::PHASES;
  localparam int     CIDX_W    = $clog2(CDEPTH);
  localparam int     LSB_UV    = (2 * acs_pkg::REF_UV) / ((1 << SAMPLE_BITS) - 1);
  localparam longint MV_MUL    = ((longint'(LSB_UV) << acs_pkg::MV_SHIFT) +
                                  longint'(acs_pkg::MV_DIV) - 1) /
                                 longint'(acs_pkg::MV_DIV);
  localparam int     MV_PROD_W = SAMPLE_BITS + acs_pkg::MV_MUL_W;
  localparam logic [acs_pkg::MV_MUL_W-1:0] MV_MUL_C = acs_pkg::MV_MUL_W'(MV_MUL);

  // Configuration registers.
  logic [acs_pkg::COUNT_W-1:0] conn_q;
  logic [acs_pkg::MASK_W-1:0]  cmask_q;
  logic [acs_pkg::MAP_W-1:0]   cmap_q;

  // Sequencing state.
  logic                         halted_q;
  logic                         busy_q;
  logic                         pend_scan_q;
  logic [acs_pkg::WORD_W-1:0]   last_cmd_q;
  logic [acs_pkg::PORT_W-1:0]   cport_q;
  logic [acs_pkg::PHASE_W-1:0]  cphase_q;
  logic [POS_W-1:0]             pos_q;
  logic [CH_W-1:0]              ci_q;

  // Stores.
  logic [SAMPLE_BITS-1:0]       sample_q [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0]       color_q  [CDEPTH];
  logic [acs_pkg::WORD_W-1:0]   stage_q  [NUM_CHANNELS];

  // Result register payload.
  logic                         issued_q;
  logic [acs_pkg::WORD_W-1:0]   cmdw_q;
  logic                         scan_q;
  logic [acs_pkg::PERIOD_W-1:0] period_q;
  logic [acs_pkg::VALUE_W-1:0]  value_q;
  logic                         stopped_q;

  // Decode of the offered item.
  logic is_tick, is_single, is_scan, is_mv, is_color;
  assign is_tick   = (kind_i == acs_pkg::KIND_TICK);
  assign is_single = (kind_i == acs_pkg::KIND_SINGLE);
  assign is_scan   = (kind_i == acs_pkg::KIND_SCAN);
  assign is_mv     = (kind_i == acs_pkg::KIND_MV);
  assign is_color  = (kind_i == acs_pkg::KIND_COLOR);

  // Current color port state and the following port.
  logic                        color_on;
  logic [acs_pkg::PORT_W-1:0]  next_port;
  logic [acs_pkg::PORT_W:0]    port_inc;
  assign color_on  = cmask_q[cport_q];
  assign port_inc  = {1'b0, cport_q} + 1'b1;
  assign next_port = (port_inc >= (acs_pkg::PORT_W + 1)'(NUM_PORTS)) ?
                     '0 : port_inc[acs_pkg::PORT_W-1:0];

  // Tick: period and command.
  logic [acs_pkg::PERIOD_W-1:0] period;
  logic [acs_pkg::CHAN_W-1:0]   map_ch;
  logic [acs_pkg::WORD_W-1:0]   new_cmd;
  logic                         scan_prev;
  logic                         can_issue;
  always_comb begin
    if (conn_q == '0) begin
      period = acs_pkg::PERIOD_SLOW;
    end else if (color_on) begin
      period = acs_pkg::PERIOD_COLOR;
    end else begin
      period = acs_pkg::PERIOD_FAST;
    end
  end
  assign map_ch    = cmap_q[{cport_q, 2'b00} +: acs_pkg::CHAN_W];
  assign new_cmd   = (color_on && (cphase_q != acs_pkg::LAST_PHASE)) ?
                     (acs_pkg::CMD_MANUAL_BASE |
                      (acs_pkg::WORD_W'(map_ch) << acs_pkg::CMD_CH_SHIFT)) :
                     acs_pkg::CMD_AUTO;
  assign scan_prev = (last_cmd_q == acs_pkg::CMD_AUTO);
  assign can_issue = !halted_q && !busy_q;

  // Reply acceptance conditions.
  logic single_ok, scan_ok, scan_final;
  assign single_ok  = !halted_q && busy_q && !pend_scan_q;
  assign scan_ok    = !halted_q && busy_q && pend_scan_q;
  assign scan_final = (pos_q == POS_W'(NUM_CHANNELS));

  // Color store write index and read.
  logic [CIDX_W-1:0]          cw_idx, cr_idx;
  logic                       port_ok;
  logic [acs_pkg::VALUE_W-1:0] color_val;
  assign cw_idx    = CIDX_W'({cport_q, cphase_q});
  assign cr_idx    = CIDX_W'({port_i, color_index_i});
  assign port_ok   = ({1'b0, port_i} < (acs_pkg::PORT_W + 1)'(NUM_PORTS));
  assign color_val = port_ok ? acs_pkg::VALUE_W'(color_q[cr_idx]) : '0;

  // Millivolt read: sample times the scaled reciprocal, then a right shift.
  logic                        ch_ok;
  logic [SAMPLE_BITS-1:0]      mv_raw;
  logic [MV_PROD_W-1:0]        mv_prod;
  logic [acs_pkg::VALUE_W-1:0] mv_val;
  assign ch_ok   = ({1'b0, channel_i} < (acs_pkg::CHAN_W + 1)'(NUM_CHANNELS));
  assign mv_raw  = ch_ok ? sample_q[channel_i[CH_W-1:0]] : '0;
  assign mv_prod = MV_PROD_W'(mv_raw) * MV_PROD_W'(MV_MUL_C);
  assign mv_val  = mv_prod[acs_pkg::MV_SHIFT +: acs_pkg::VALUE_W];

  // Commit of one staged word.
  logic [acs_pkg::WORD_W-1:0] cw_word;
  logic [acs_pkg::CHAN_W-1:0] cw_ch;
  logic                       cw_ok;
  assign cw_word = stage_q[ci_q];
  assign cw_ch   = cw_word[acs_pkg::WORD_W-1 -: acs_pkg::CHAN_W];
  assign cw_ok   = ({1'b0, cw_ch} < (acs_pkg::CHAN_W + 1)'(NUM_CHANNELS));

  // Status to the controller.
  assign sts_o.res_now      = is_tick || is_mv || is_color;
  assign sts_o.commit_start = is_scan && scan_ok && scan_final && !transfer_error_i;
  assign sts_o.commit_last  = (ci_q == '0);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q  <= '0;
      cmask_q <= '0;
      cmap_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        acs_pkg::CFG_CONNECTED: conn_q  <= cfg_wdata_i[acs_pkg::COUNT_W-1:0];
        acs_pkg::CFG_COLOR_MSK: cmask_q <= cfg_wdata_i[acs_pkg::MASK_W-1:0];
        acs_pkg::CFG_CHAN_MAP:  cmap_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencing state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q    <= 1'b0;
      busy_q      <= 1'b0;
      pend_scan_q <= 1'b0;
      last_cmd_q  <= '0;
      cport_q     <= '0;
      cphase_q    <= '0;
      pos_q       <= '0;
      ci_q        <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (is_tick && can_issue) begin
          last_cmd_q  <= new_cmd;
          busy_q      <= 1'b1;
          pend_scan_q <= scan_prev;
          pos_q       <= '0;
        end
        if (is_single && single_ok) begin
          busy_q <= 1'b0;
          if (transfer_error_i) begin
            halted_q <= 1'b1;
          end else if (color_on) begin
            cphase_q <= cphase_q + 1'b1;
            if (cphase_q == acs_pkg::LAST_PHASE) begin
              cport_q <= next_port;
            end
          end
        end
        if (is_scan && scan_ok) begin
          if (!scan_final) begin
            pos_q <= pos_q + 1'b1;
          end else begin
            pos_q  <= '0;
            busy_q <= 1'b0;
            if (transfer_error_i) begin
              halted_q <= 1'b1;
            end else begin
              ci_q <= CH_W'(NUM_CHANNELS - 1);
              if (!color_on) begin
                cport_q  <= next_port;
                cphase_q <= '0;
              end
            end
          end
        end
      end
      if (cmd_i.commit_step) begin
        ci_q <= ci_q - 1'b1;
      end
    end
  end

  // Sample and color stores; commit runs from the last staged word down.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sample_q[i] <= '0;
      end
      for (int i = 0; i < CDEPTH; i++) begin
        color_q[i] <= '0;
      end
    end else begin
      if (cmd_i.accept && is_single && single_ok && !transfer_error_i && color_on) begin
        color_q[cw_idx] <= rx_word_i[SAMPLE_BITS-1:0];
      end
      if (cmd_i.commit_step && cw_ok) begin
        sample_q[cw_ch[CH_W-1:0]] <= cw_word[SAMPLE_BITS-1:0];
      end
    end
  end

  // Frame staging: word zero of a frame is dropped.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_scan && scan_ok && (pos_q != '0)) begin
      stage_q[CH_W'(pos_q - 1'b1)] <= rx_word_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_tick) begin
      issued_q  <= can_issue;
      cmdw_q    <= can_issue ? new_cmd : '0;
      scan_q    <= can_issue && scan_prev;
      period_q  <= period;
      value_q   <= '0;
      stopped_q <= halted_q;
    end else if (cmd_i.accept && (is_mv || is_color)) begin
      issued_q  <= 1'b0;
      cmdw_q    <= '0;
      scan_q    <= 1'b0;
      period_q  <= acs_pkg::PERIOD_SLOW;
      value_q   <= is_mv ? mv_val : color_val;
      stopped_q <= halted_q;
    end
  end

  assign issued_o        = issued_q;
  assign command_word_o  = cmdw_q;
  assign scan_frame_o    = scan_q;
  assign period_select_o = period_q;
  assign read_value_o    = value_q;
  assign stopped_o       = stopped_q;

endmodule

[sv/adc_scan_sequencer.sv]
// ----------------------------------------------------------------------------
// adc_scan_sequencer
// Poll sequencer for a multi-channel converter: issues commands on ticks,
// collects single replies and scan frames, and answers sample reads.
// ----------------------------------------------------------------------------
// Ticks, millivolt reads and color reads: result in the output register in the
// cycle after the item is taken; next item may follow in the next cycle unless
// the output stalls. Final scan word: commits one staged word per cycle.
// Reset clears at once all but the staging store and result register payload.
module adc_scan_sequencer #(
  parameter int NUM_CHANNELS = acs_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_PORTS    = acs_pkg::NUM_PORTS_DEF,
  parameter int SAMPLE_BITS  = acs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [acs_pkg::MAP_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [acs_pkg::KIND_W-1:0]    kind_i,
  input  logic [acs_pkg::WORD_W-1:0]    rx_word_i,
  input  logic                          transfer_error_i,
  input  logic [acs_pkg::CHAN_W-1:0]    channel_i,
  input  logic [acs_pkg::PORT_W-1:0]    port_i,
  input  logic [acs_pkg::PHASE_W-1:0]   color_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          issued_o,
  output logic [acs_pkg::WORD_W-1:0]    command_word_o,
  output logic                          scan_frame_o,
  output logic [acs_pkg::PERIOD_W-1:0]  period_select_o,
  output logic [acs_pkg::VALUE_W-1:0]   read_value_o,
  output logic                          stopped_o
);

  acs_pkg::acs_cmd_t cmd;
  acs_pkg::acs_sts_t sts;

  // Controller.
  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  acs_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_PORTS    (NUM_PORTS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .kind_i           (kind_i),
    .rx_word_i        (rx_word_i),
    .transfer_error_i (transfer_error_i),
    .channel_i        (channel_i),
    .port_i           (port_i),
    .color_index_i    (color_index_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .issued_o         (issued_o),
    .command_word_o   (command_word_o),
    .scan_frame_o     (scan_frame_o),
    .period_select_o  (period_select_o),
    .read_value_o     (read_value_o),
    .stopped_o        (stopped_o)
  );

endmodule
